[hw/rtl/ffga_pkg.sv]
// Package for the first-fit grid allocator: stream field layouts,
// operation and status codes, register indexes and the sequencer states.
// No dependencies.
package ffga_pkg;

  // Field widths of the input and result words.
  localparam int unsigned TAG_W    = 5;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned ROWS_REG_W = 6;
  localparam int unsigned COLS_REG_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 4'd1;

  localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RST = 6'd20;
  localparam logic [COLS_REG_W-1:0] GRID_COLS_RST = 7'd50;

  localparam logic [TAG_W-1:0] TAG_FREE = '0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_READ    = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ASCAN = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_RSCAN = 7'b0010000,
    S_RWAIT = 7'b0100000,
    S_RESLT = 7'b1000000
  } state_e;

endpackage

[hw/rtl/ffga_cell_store.sv]
// Owner store of the allocator: one write port and one registered read port.
// Depends on ffga_pkg for the tag width.
module ffga_cell_store
  import ffga_pkg::*;
#(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [TAG_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [TAG_W-1:0] rdata_o
);

  logic [TAG_W-1:0] mem_q [DEPTH];
  logic [TAG_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: the data follows in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/first_fit_grid_allocator.sv]
// First-fit grid allocator: a sequencer that walks the owner store one cell a cycle.
// A read looks up one cell; a release scans the grid; an allocate scans and fills,
// paced by the single read port and the single write port of the owner store.
// One word is worked on at a time; a finished result waits in the output register.
// After reset the store is cleared one cell a cycle, all MAX_ROWS*MAX_COLS cells, while
// input is held off; configuration writes are taken at any time.
module first_fit_grid_allocator
  import ffga_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input words.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: owner_tag[4:0], request_size[16:5], cell_row[21:17], cell_col[27:22]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // tuser: action[1:0]
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  // Result words.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: start_row[4:0], start_col[10:5], cell_owner[15:11]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  // tuser: status[1:0]
  output logic [STATUS_W-1:0]   m_axis_tuser,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  state_e state_q, state_d;

  logic [ROWS_REG_W-1:0] grid_rows_q;
  logic [COLS_REG_W-1:0] grid_cols_q;
  logic [ROWS_REG_W-1:0] rows_use;
  logic [COLS_REG_W-1:0] cols_use;

  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [RW-1:0]     scan_row_q, scan_row_d;
  logic [CW-1:0]     scan_col_q, scan_col_d;
  logic              issue_q, issue_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic [RW-1:0]     rd_row_q, rd_row_d;
  logic [CW-1:0]     rd_col_q, rd_col_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [SIZE_W-1:0] run_q, run_d;
  logic [RW-1:0]     run_row_q, run_row_d;
  logic [CW-1:0]     run_col_q, run_col_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [SIZE_W-1:0] size_q, size_d;

  status_e           res_status_q, res_status_d;
  logic [ROW_W-1:0]  res_row_q, res_row_d;
  logic [COL_W-1:0]  res_col_q, res_col_d;
  logic [TAG_W-1:0]  res_owner_q, res_owner_d;

  logic                out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0] out_data_q, out_data_d;
  logic [STATUS_W-1:0] out_user_q, out_user_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [TAG_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [TAG_W-1:0] mem_rdata;

  logic              in_fire;
  logic [TAG_W-1:0]  in_tag;
  logic [SIZE_W-1:0] in_size;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              grid_empty;
  logic              col_wrap;
  logic              row_wrap;
  logic              in_range;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     in_addr;
  logic [SIZE_W:0]   run_next;

  // Grid size in use: the registers bounded by the store dimensions.
  assign rows_use = (32'(grid_rows_q) > MAX_ROWS) ? ROWS_REG_W'(MAX_ROWS) : grid_rows_q;
  assign cols_use = (32'(grid_cols_q) > MAX_COLS) ? COLS_REG_W'(MAX_COLS) : grid_cols_q;
  assign grid_empty = (rows_use == '0) || (cols_use == '0);

  // Unpack the input word.
  assign in_tag  = s_axis_tdata[4:0];
  assign in_size = s_axis_tdata[16:5];
  assign in_row  = s_axis_tdata[21:17];
  assign in_col  = s_axis_tdata[27:22];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Cell addresses are row * MAX_COLS + col in the store.
  assign scan_addr = AW'(32'(scan_row_q) * MAX_COLS + 32'(scan_col_q));
  assign in_addr   = AW'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign in_range  = (32'(in_row) < 32'(rows_use)) && (32'(in_col) < 32'(cols_use));

  // Row-major walk of the scan counters.
  assign col_wrap = (32'(scan_col_q) + 32'd1) == 32'(cols_use);
  assign row_wrap = (32'(scan_row_q) + 32'd1) == 32'(rows_use);
  assign run_next = {1'b0, run_q} + 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_ROWS_RST;
      grid_cols_q <= GRID_COLS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_GRID_ROWS) begin
        grid_rows_q <= cfg_data_i[ROWS_REG_W-1:0];
      end else if (cfg_index_i == REG_GRID_COLS) begin
        grid_cols_q <= cfg_data_i[COLS_REG_W-1:0];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    scan_row_d   = scan_row_q;
    scan_col_d   = scan_col_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = 1'b0;
    rd_row_d     = scan_row_q;
    rd_col_d     = scan_col_q;
    rd_addr_d    = scan_addr;
    run_d        = run_q;
    run_row_d    = run_row_q;
    run_col_d    = run_col_q;
    tag_d        = tag_q;
    size_d       = size_q;
    res_status_d = res_status_q;
    res_row_d    = res_row_q;
    res_col_d    = res_col_q;
    res_owner_d  = res_owner_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    mem_we       = 1'b0;
    mem_waddr    = scan_addr;
    mem_wdata    = tag_q;
    mem_raddr    = scan_addr;

    // Read issue for both scans: one cell per cycle while cells remain.
    if ((state_q == S_ASCAN || state_q == S_RSCAN) && issue_q) begin
      rd_vld_d  = 1'b1;
      rd_last_d = col_wrap && row_wrap;
      if (col_wrap) begin
        scan_col_d = '0;
        scan_row_d = RW'(32'(scan_row_q) + 32'd1);
        if (row_wrap) begin
          issue_d = 1'b0;
        end
      end else begin
        scan_col_d = CW'(32'(scan_col_q) + 32'd1);
      end
    end

    case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = TAG_FREE;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          tag_d        = in_tag;
          size_d       = in_size;
          scan_row_d   = '0;
          scan_col_d   = '0;
          issue_d      = 1'b1;
          run_d        = '0;
          res_status_d = ST_DONE;
          res_row_d    = '0;
          res_col_d    = '0;
          res_owner_d  = '0;
          state_d      = S_RESLT;
          case (action_e'(s_axis_tuser))
            ACT_ALLOC: begin
              if (in_tag == TAG_FREE || in_size == '0 || grid_empty) begin
                res_status_d = ST_NOSPACE;
              end else begin
                state_d = S_ASCAN;
              end
            end
            ACT_RELEASE: begin
              if (in_tag != TAG_FREE && !grid_empty) begin
                state_d = S_RSCAN;
              end
            end
            ACT_READ: begin
              if (in_range) begin
                mem_raddr = in_addr;
                state_d   = S_RWAIT;
              end else begin
                res_status_d = ST_OUTSIDE;
              end
            end
            default: begin
              res_status_d = ST_DONE;
            end
          endcase
        end
      end

      // First-fit search: count free cells, restart the run at an owned one.
      S_ASCAN: begin
        if (rd_vld_q) begin
          if (mem_rdata == TAG_FREE) begin
            run_d = run_next[SIZE_W-1:0];
            if (run_q == '0) begin
              run_row_d = rd_row_q;
              run_col_d = rd_col_q;
            end
            if (run_next == {1'b0, size_q}) begin
              // Run complete: fill it from its first cell.
              scan_row_d = (run_q == '0) ? rd_row_q : run_row_q;
              scan_col_d = (run_q == '0) ? rd_col_q : run_col_q;
              res_row_d  = ROW_W'(32'((run_q == '0) ? rd_row_q : run_row_q));
              res_col_d  = COL_W'(32'((run_q == '0) ? rd_col_q : run_col_q));
              run_d      = '0;
              state_d    = S_FILL;
            end else if (rd_last_q) begin
              res_status_d = ST_NOSPACE;
              state_d      = S_RESLT;
            end
          end else begin
            run_d = '0;
            if (rd_last_q) begin
              res_status_d = ST_NOSPACE;
              state_d      = S_RESLT;
            end
          end
        end
      end

      // Write the tag into the run, one cell per cycle.
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = scan_addr;
        mem_wdata = tag_q;
        run_d     = run_next[SIZE_W-1:0];
        if (col_wrap) begin
          scan_col_d = '0;
          scan_row_d = RW'(32'(scan_row_q) + 32'd1);
        end else begin
          scan_col_d = CW'(32'(scan_col_q) + 32'd1);
        end
        if (run_next == {1'b0, size_q}) begin
          res_status_d = ST_DONE;
          state_d      = S_RESLT;
        end
      end

      // Release: free each cell whose owner matches, in the cycle after its read.
      S_RSCAN: begin
        if (rd_vld_q) begin
          if (mem_rdata == tag_q) begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_q;
            mem_wdata = TAG_FREE;
          end
          if (rd_last_q) begin
            state_d = S_RESLT;
          end
        end
      end

      S_RWAIT: begin
        res_owner_d = mem_rdata;
        state_d     = S_RESLT;
      end

      // Hand the result to the output register once it is free.
      S_RESLT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_owner_q, res_col_q, res_row_q};
          out_user_d  = res_status_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    scan_row_q   <= scan_row_d;
    scan_col_q   <= scan_col_d;
    rd_last_q    <= rd_last_d;
    rd_row_q     <= rd_row_d;
    rd_col_q     <= rd_col_d;
    rd_addr_q    <= rd_addr_d;
    run_q        <= run_d;
    run_row_q    <= run_row_d;
    run_col_q    <= run_col_d;
    tag_q        <= tag_d;
    size_q       <= size_d;
    res_status_q <= res_status_d;
    res_row_q    <= res_row_d;
    res_col_q    <= res_col_d;
    res_owner_q  <= res_owner_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  ffga_cell_store #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // The store is written only while clearing, filling a run or releasing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_FILL || state_q == S_RSCAN))
    else $error("store written outside a write phase");

  // A fill never leaves the grid in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |->
      (32'(scan_row_q) < 32'(rows_use) && 32'(scan_col_q) < 32'(cols_use)))
    else $error("fill address outside the grid");

  // A new result is only loaded from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) && $past(rst_ni))
      |-> $past(state_q == S_RESLT))
    else $error("result loaded outside the result state");

  // A release write always follows a read issued by the release scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RSCAN && mem_we) |-> ($past(state_q == S_RSCAN) && rd_vld_q))
    else $error("release write without a matching read");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the first-fit grid allocator: a table of directed words,
// then random words over several grid sizes, checked against an in-bench cell-owner model.
// Depends on ffga_pkg and first_fit_grid_allocator.
module tb_top
  import ffga_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_MAX_ROWS = 32;
  localparam int unsigned GRID_MAX_COLS = 64;
  localparam int unsigned CELL_TOTAL    = GRID_MAX_ROWS * GRID_MAX_COLS;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned IDLE_SETTLE   = 4;
  localparam int unsigned NEVER         = 32'hFFFF_FFFF;

  // The action code that the block does not define.
  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TAG_W-1:0]    tag;
    logic [SIZE_W-1:0]   size;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    start_row;
    logic [COL_W-1:0]    start_col;
    logic [TAG_W-1:0]    owner;
  } result_t;

  // One row of the directed table: either a register write or a word.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    word_t                 w;
    logic                  typed;
    result_t               res;
  } step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [ACTION_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Model state: owner of every cell and the two dimension registers.
  logic [TAG_W-1:0]      cell_owners [CELL_TOTAL];
  logic [ROWS_REG_W-1:0] grid_rows_q;
  logic [COLS_REG_W-1:0] grid_cols_q;
  logic [TAG_W-1:0]      owned_tags [$];

  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;
  bit          hold_request = 1'b0;

  first_fit_grid_allocator #(
    .MAX_ROWS(GRID_MAX_ROWS),
    .MAX_COLS(GRID_MAX_COLS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned live_rows();
    return (grid_rows_q < GRID_MAX_ROWS) ? grid_rows_q : GRID_MAX_ROWS;
  endfunction

  function automatic int unsigned live_cols();
    return (grid_cols_q < GRID_MAX_COLS) ? grid_cols_q : GRID_MAX_COLS;
  endfunction

  // Store address of the k-th cell in row-major scan order.
  function automatic int unsigned cell_addr(input int unsigned k, input int unsigned cols);
    return (k / cols) * GRID_MAX_COLS + (k % cols);
  endfunction

  // Applies one word to the cell-owner model and returns the result it must produce.
  function automatic result_t predict_grid_op(input word_t w);
    result_t     res;
    int unsigned rows, cols, cells, k, run, run_at;
    bit          found;
    res = '0;
    rows = live_rows();
    cols = live_cols();
    cells = rows * cols;
    found = 1'b0;
    run = 0;
    run_at = 0;
    case (w.action)
      ACT_ALLOC: begin
        res.status = ST_NOSPACE;
        if (w.tag != TAG_FREE && w.size != 0) begin
          for (k = 0; k < cells && !found; k++) begin
            if (cell_owners[cell_addr(k, cols)] == TAG_FREE) begin
              if (run == 0) run_at = k;
              run++;
              if (run == w.size) found = 1'b1;
            end else begin
              run = 0;
            end
          end
        end
        if (found) begin
          for (k = run_at; k < run_at + w.size; k++) cell_owners[cell_addr(k, cols)] = w.tag;
          res.status    = ST_DONE;
          res.start_row = ROW_W'(run_at / cols);
          res.start_col = COL_W'(run_at % cols);
          owned_tags.push_back(w.tag);
        end
      end
      ACT_RELEASE: begin
        if (w.tag != TAG_FREE) begin
          for (k = 0; k < cells; k++) begin
            if (cell_owners[cell_addr(k, cols)] == w.tag) begin
              cell_owners[cell_addr(k, cols)] = TAG_FREE;
            end
          end
        end
      end
      ACT_READ: begin
        if (w.row < rows && w.col < cols) begin
          res.owner = cell_owners[w.row * GRID_MAX_COLS + w.col];
        end else begin
          res.status = ST_OUTSIDE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Short gaps are common, long ones rare.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    return $urandom_range(50, 12);
  endfunction

  // Mostly well-formed work on the current grid; every field is randomized first so
  // that the unused ones toggle too.
  function automatic word_t random_word();
    word_t       w;
    int unsigned rows, cols, cells, pick, i;
    rows = live_rows();
    cols = live_cols();
    cells = rows * cols;
    w.tag  = TAG_W'($urandom_range(31, 0));
    w.size = SIZE_W'($urandom_range(4095, 0));
    w.row  = ROW_W'($urandom_range(31, 0));
    w.col  = COL_W'($urandom_range(63, 0));
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      w.action = ACT_ALLOC;
      if ($urandom_range(19, 0) != 0) w.tag = TAG_W'($urandom_range(31, 1));
      else w.tag = TAG_FREE;
      pick = $urandom_range(99, 0);
      if (cells == 0) begin
        // Keep the random size.
      end else if (pick < 70) begin
        w.size = SIZE_W'($urandom_range((cells + 3) / 4, 1));
      end else if (pick < 85) begin
        w.size = SIZE_W'($urandom_range(cells, 1));
      end else if (pick < 92) begin
        w.size = pick[0] ? SIZE_W'(cells) : '0;
      end
    end else if (pick < 70) begin
      w.action = ACT_RELEASE;
      if (owned_tags.size() != 0 && $urandom_range(4, 0) != 0) begin
        i = $urandom_range(owned_tags.size() - 1, 0);
        w.tag = owned_tags[i];
        owned_tags.delete(i);
      end
    end else if (pick < 95) begin
      w.action = ACT_READ;
      if (cells != 0 && $urandom_range(6, 0) != 0) begin
        w.row = ROW_W'($urandom_range(rows - 1, 0));
        w.col = COL_W'($urandom_range(cols - 1, 0));
      end
    end else begin
      w.action = ACT_UNDEF;
    end
    return w;
  endfunction

  function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic step_t word_step(
    input logic [ACTION_W-1:0] action, input logic [TAG_W-1:0] tag,
    input logic [SIZE_W-1:0] size, input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
    input logic typed, input logic [STATUS_W-1:0] status,
    input logic [ROW_W-1:0] srow, input logic [COL_W-1:0] scol, input logic [TAG_W-1:0] owner);
    step_t s;
    s = '0;
    s.w = '{action: action, tag: tag, size: size, row: row, col: col};
    s.typed = typed;
    s.res = '{status: status, start_row: srow, start_col: scol, owner: owner};
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch: %s", what);
  endtask

  // Offers one word and records its expected result once it is taken.
  task automatic send_word(input word_t w, input logic typed, input result_t typed_res);
    result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({w.col, w.row, w.size, w.tag});
    s_axis_tuser  <= w.action;
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_grid_op(w);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic pace_sender(input bit steady);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds input off until every expected result has come back.
  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_GRID_ROWS) grid_rows_q = val[ROWS_REG_W-1:0];
    else if (idx == REG_GRID_COLS) grid_cols_q = val[COLS_REG_W-1:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] rows_val,
                                  input logic [CFG_DATA_W-1:0] cols_val,
                                  input int unsigned count, input bit steady,
                                  input int unsigned hold_at, input int unsigned drain_at);
    int unsigned i;
    wait_for_idle();
    write_register(REG_GRID_ROWS, rows_val);
    write_register(REG_GRID_COLS, cols_val);
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      if (i == drain_at) wait_for_idle();
      send_word(random_word(), 1'b0, '0);
      pace_sender(steady);
    end
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin : result_sink
    int unsigned stall, hold, span;
    bit          calm;
    stall = 0;
    hold = 0;
    span = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        calm = ($urandom_range(3, 0) == 0);
        span = $urandom_range(600, 100);
      end else begin
        span--;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm) stall = idle_len();
      end
    end
  end

  // Each result word is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status    = m_axis_tuser;
      got.start_row = m_axis_tdata[ROW_W-1:0];
      got.start_col = m_axis_tdata[ROW_W+COL_W-1:ROW_W];
      got.owner     = m_axis_tdata[ROW_W+COL_W+TAG_W-1:ROW_W+COL_W];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", result_index));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "result %0d status %0d/%0d row %0d/%0d col %0d/%0d owner %0d/%0d (got/exp)",
            result_index, got.status, want.status, got.start_row, want.start_row,
            got.start_col, want.start_col, got.owner, want.owner));
        end
      end
      result_index++;
    end
  end

  initial begin : stimulus
    step_t plan [$];
    foreach (cell_owners[k]) cell_owners[k] = TAG_FREE;
    grid_rows_q = GRID_ROWS_RST;
    grid_cols_q = GRID_COLS_RST;

    // Directed table. Grid starts at its reset size of 20 x 50 (1000 cells).
    plan.push_back(word_step(ACT_READ,     0,    0,  0,  0, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_READ,     0,    0, 19, 49, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_READ,     0,    0, 20,  0, 1, ST_OUTSIDE, 0,  0, 0));
    plan.push_back(word_step(ACT_READ,     0,    0,  0, 50, 1, ST_OUTSIDE, 0,  0, 0));
    plan.push_back(word_step(ACT_READ,    31, 4095, 31, 63, 1, ST_OUTSIDE, 0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,    5,    0,  0,  0, 1, ST_NOSPACE, 0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,    0,   10,  0,  0, 1, ST_NOSPACE, 0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,   31, 4095,  0,  0, 1, ST_NOSPACE, 0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,    1, 1001,  0,  0, 1, ST_NOSPACE, 0,  0, 0));
    // A run of 60 crosses the end of the first row.
    plan.push_back(word_step(ACT_ALLOC,    1,   60,  0,  0, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_READ,     0,    0,  1,  9, 0, ST_DONE,    0,  0, 0));
    // The rest of the grid exactly, then nothing fits.
    plan.push_back(word_step(ACT_ALLOC,   31,  940,  0,  0, 1, ST_DONE,    1, 10, 0));
    plan.push_back(word_step(ACT_ALLOC,    2,    1,  0,  0, 1, ST_NOSPACE, 0,  0, 0));
    plan.push_back(word_step(ACT_RELEASE,  0,    0,  0,  0, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_RELEASE,  1,    0,  0,  0, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,    3,   61,  0,  0, 0, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,    3,   60,  0,  0, 0, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_UNDEF,   31, 4095, 31, 63, 1, ST_DONE,    0,  0, 0));
    // Empty grid.
    plan.push_back(cfg_step(REG_GRID_ROWS, 8'h00));
    plan.push_back(word_step(ACT_ALLOC,    4,    1,  0,  0, 1, ST_NOSPACE, 0,  0, 0));
    plan.push_back(word_step(ACT_READ,     0,    0,  0,  0, 1, ST_OUTSIDE, 0,  0, 0));
    // Oversized registers clamp to the full store; old contents stay where they were.
    plan.push_back(cfg_step(REG_GRID_ROWS, 8'hFF));
    plan.push_back(cfg_step(REG_GRID_COLS, 8'hFF));
    plan.push_back(word_step(ACT_READ,     0,    0, 31, 63, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_ALLOC,    9,   20,  0,  0, 0, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_RELEASE, 31,    0,  0,  0, 1, ST_DONE,    0,  0, 0));
    plan.push_back(word_step(ACT_READ,     0,    0,  1, 10, 0, ST_DONE,    0,  0, 0));
    // Smallest grid: one cell, already owned.
    plan.push_back(cfg_step(REG_GRID_ROWS, 8'd1));
    plan.push_back(cfg_step(REG_GRID_COLS, 8'd1));
    plan.push_back(word_step(ACT_ALLOC,    7,    1,  0,  0, 0, ST_DONE,    0,  0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_for_idle();
        write_register(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].res);
        pace_sender(1'b0);
      end
    end

    // Random phases over a range of grid shapes.
    run_random_phase(8'd20, 8'd50, 50, 1'b0, NEVER, NEVER);
    run_random_phase(8'd4, 8'd8, 80, 1'b0, 10, NEVER);
    run_random_phase(8'd63, 8'd127, 30, 1'b1, NEVER, NEVER);
    run_random_phase(8'd32, 8'd1, 50, 1'b0, NEVER, NEVER);
    run_random_phase(8'd7, 8'd13, 55, 1'b0, NEVER, 35);

    wait_for_idle();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : run_limit
    #80_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[first_fit_grid_allocator.f]
hw/rtl/ffga_pkg.sv
hw/rtl/ffga_cell_store.sv
hw/rtl/first_fit_grid_allocator.sv
dv/tb_top.sv
